// ===== src/rgb_to_hsv_converter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// rgb to hsv converter assertion macros
// shared concurrent assertion wrappers, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH

// property must hold at every edge outside reset
`define RHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle of the antecedent
`define RHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// shared constants of the rgb to hsv converter
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int unsigned SampleBitsDef   = 10;
  localparam int unsigned FractionBitsDef = 6;

  // fixed result field widths
  localparam int unsigned HueW = 15;
  localparam int unsigned SatW = 13;
  localparam int unsigned ValW = 15;

endpackage

// ===== src/rhc_div.sv =====
// ----------------------------------------------------------------------------
// rhc_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module rhc_div #(
  parameter int unsigned NW = 25,
  parameter int unsigned DW = 10,
  parameter int unsigned QW = 15
) (
  input  logic          clk_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [QW-1:0] quotient_o
);

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] dvs_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [DW-1:0] dvs_in;
    logic [QW-1:0] quo_in;
    logic [NW-1:0] shifted;
    logic          ge;
    logic [NW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    if (i == 0) begin : g_first
      assign rem_in = dividend_i;
      assign dvs_in = divisor_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign dvs_in = dvs_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    // divisor aligned to the weight of this quotient bit
    assign shifted = NW'(dvs_in) << (QW - 1 - i);
    assign ge      = rem_in >= shifted;
    assign rem_d   = ge ? (rem_in - shifted) : rem_in;
    assign quo_d   = {quo_in[QW-2:0], ge};

    always_ff @(posedge clk_i) begin
      rem_q[i] <= rem_d;
      dvs_q[i] <= dvs_in;
      quo_q[i] <= quo_d;
    end
  end

  assign quotient_o = quo_q[QW-1];

endmodule

// ===== src/rgb_to_hsv_converter_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit
// raw rgb sample to hue / saturation / value, fixed point, fully pipelined
// ----------------------------------------------------------------------------
//
//  port group        dir  handshake          words
//  ----------------  ---  -----------------  --------------------------------
//  red/green/blue_i  in   start, busy        one raw colour sample
//  hue/sat/bright_o  out  done_o strobe      one hsv result
//
//  - one word accepted every cycle, busy is always low
//  - results pass through the input register, stage 1, stage 2, QW divider
//    stages and the output register, QW = clog2(360 * 2^FRACTION_BITS) (15 by
//    default), two pipelined restoring dividers, one quotient bit per stage
//  - reset clears the valid bits only, data registers are not reset
//  - results come out in input order, each on done_o for a single cycle
//
`include "rgb_to_hsv_converter_unit_assert.svh"

module rgb_to_hsv_converter_unit
  import rhc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS   = SampleBitsDef,
  parameter int unsigned FRACTION_BITS = FractionBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [SAMPLE_BITS-1:0] red_i,
  input  logic [SAMPLE_BITS-1:0] green_i,
  input  logic [SAMPLE_BITS-1:0] blue_i,
  output logic                   done_o,
  output logic [HueW-1:0]        hue_o,
  output logic [SatW-1:0]        saturation_o,
  output logic [ValW-1:0]        brightness_o
);

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned FB  = FRACTION_BITS;
  // quotient bits: hue below 360 * 2^FB, saturation at most 100 * 2^FB
  localparam int unsigned QW  = $clog2(360 * (1 << FB));
  localparam int unsigned NW  = SB + QW;
  localparam int unsigned SW  = NW + 2;
  // brightness: x = hi * 100 * 2^FB, divided by 255 via reciprocal
  localparam int unsigned XW  = SB + 7 + FB;
  localparam int unsigned MW  = XW - 7;
  localparam int unsigned PW  = XW + MW;
  localparam int unsigned BQW = XW - 7;

  localparam logic signed [SW-1:0] K60  = SW'(60  * (1 << FB));
  localparam logic signed [SW-1:0] K120 = SW'(120 * (1 << FB));
  localparam logic signed [SW-1:0] K240 = SW'(240 * (1 << FB));
  localparam logic signed [SW-1:0] K360 = SW'(360 * (1 << FB));
  localparam logic [NW-1:0]        K100 = NW'(100 * (1 << FB));
  localparam logic [XW-1:0]        KV   = XW'(100 * (1 << FB));
  localparam logic [MW-1:0]        BM   = MW'((64'd1 << XW) / 64'd255);
  localparam logic [XW-1:0]        K255 = XW'(255);

  // bounds of the output fields after truncation to their widths
  localparam longint unsigned HueLim =
    ((360 << FB) < (1 << HueW)) ? (360 << FB) : (1 << HueW);
  localparam longint unsigned SatLim =
    ((100 << FB) < (1 << SatW)) ? (100 << FB) : ((1 << SatW) - 1);

  // dominant channel codes
  localparam logic [1:0] DomRed   = 2'd0;
  localparam logic [1:0] DomGreen = 2'd1;
  localparam logic [1:0] DomBlue  = 2'd2;

  assign busy = 1'b0;

  // stage 0: input register
  logic          s0_vld_q;
  logic [SB-1:0] s0_r_q, s0_g_q, s0_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_r_q <= red_i;
    s0_g_q <= green_i;
    s0_b_q <= blue_i;
  end

  // stage 1: max, min, dominant channel, span and signed channel difference
  logic          s1_vld_q;
  logic [SB-1:0] s1_hi_q, s1_hi_d;
  logic [SB-1:0] s1_span_q, s1_span_d;
  logic [1:0]    s1_dom_q, s1_dom_d;
  logic signed [SB:0] s1_diff_q, s1_diff_d;
  logic          s1_grey_q, s1_grey_d;
  logic [SB-1:0] lo;

  always_comb begin
    s1_hi_d = s0_r_q;
    lo      = s0_r_q;
    if (s0_g_q > s1_hi_d) s1_hi_d = s0_g_q;
    if (s0_b_q > s1_hi_d) s1_hi_d = s0_b_q;
    if (s0_g_q < lo) lo = s0_g_q;
    if (s0_b_q < lo) lo = s0_b_q;
    s1_span_d = s1_hi_d - lo;
    s1_grey_d = (s1_hi_d == lo);
    // ties go to blue, then green
    if (s1_hi_d == s0_b_q) begin
      s1_dom_d  = DomBlue;
      s1_diff_d = $signed({1'b0, s0_r_q}) - $signed({1'b0, s0_g_q});
    end else if (s1_hi_d == s0_g_q) begin
      s1_dom_d  = DomGreen;
      s1_diff_d = $signed({1'b0, s0_b_q}) - $signed({1'b0, s0_r_q});
    end else begin
      s1_dom_d  = DomRed;
      s1_diff_d = $signed({1'b0, s0_g_q}) - $signed({1'b0, s0_b_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_hi_q   <= s1_hi_d;
    s1_span_q <= s1_span_d;
    s1_dom_q  <= s1_dom_d;
    s1_diff_q <= s1_diff_d;
    s1_grey_q <= s1_grey_d;
  end

  // stage 2: dividends by constant multiplies, negative hue wrapped by 360
  logic          s2_vld_q;
  logic [NW-1:0] s2_hnum_q, s2_snum_q;
  logic [SB-1:0] s2_span_q, s2_hi_q;
  logic [XW-1:0] s2_x_q;
  logic          s2_grey_q;
  logic signed [SW-1:0] span_s, diff_s, num;

  always_comb begin
    span_s = $signed(SW'(s1_span_q));
    diff_s = SW'(s1_diff_q);
    num    = K60 * diff_s;
    case (s1_dom_q)
      DomBlue:  num = num + K240 * span_s;
      DomGreen: num = num + K120 * span_s;
      default:  num = num;
    endcase
    if (num < 0) num = num + K360 * span_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_hnum_q <= NW'(num);
    s2_snum_q <= K100 * NW'(s1_span_q);
    s2_span_q <= s1_span_q;
    s2_hi_q   <= s1_hi_q;
    s2_x_q    <= KV * XW'(s1_hi_q);
    s2_grey_q <= s1_grey_q;
  end

  // dividers, QW stages each
  logic [QW-1:0] hue_quo, sat_quo;

  rhc_div #(.NW(NW), .DW(SB), .QW(QW)) u_hue_div (
    .clk_i      (clk_i),
    .dividend_i (s2_hnum_q),
    .divisor_i  (s2_span_q),
    .quotient_o (hue_quo)
  );

  rhc_div #(.NW(NW), .DW(SB), .QW(QW)) u_sat_div (
    .clk_i      (clk_i),
    .dividend_i (s2_snum_q),
    .divisor_i  (s2_hi_q),
    .quotient_o (sat_quo)
  );

  // brightness over the first two divider stages, then delayed to line up
  logic [PW-1:0]  bp_prod_q;
  logic [XW-1:0]  bp_x_q;
  logic [BQW-1:0] bp_est;
  logic [XW-1:0]  bp_rem;
  logic [BQW-1:0] bp_quo_d;
  logic [BQW-1:0] bdly_q [QW-1];

  assign bp_est   = BQW'(bp_prod_q >> XW);
  assign bp_rem   = bp_x_q - XW'(bp_est) * K255;
  // estimate is at most one below the true quotient
  assign bp_quo_d = (bp_rem >= K255) ? (bp_est + BQW'(1)) : bp_est;

  always_ff @(posedge clk_i) begin
    bp_prod_q <= PW'(s2_x_q) * PW'(BM);
    bp_x_q    <= s2_x_q;
    bdly_q[0] <= bp_quo_d;
    for (int i = 1; i < QW - 1; i++) begin
      bdly_q[i] <= bdly_q[i-1];
    end
  end

  // valid and grey flags alongside the divider stages
  logic vld_q  [QW];
  logic grey_q [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QW; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= s2_vld_q;
      for (int i = 1; i < QW; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    grey_q[0] <= s2_grey_q;
    for (int i = 1; i < QW; i++) grey_q[i] <= grey_q[i-1];
  end

  // output register, fields truncated to their widths
  logic                 done_q;
  logic [HueW-1:0]      hue_q, hue_d;
  logic [SatW-1:0]      sat_q, sat_d;
  logic [ValW-1:0]      val_q, val_d;
  logic [QW+HueW-1:0]   hue_ext;
  logic [QW+SatW-1:0]   sat_ext;
  logic [BQW+ValW-1:0]  val_ext;

  assign hue_ext = {{HueW{1'b0}}, hue_quo};
  assign sat_ext = {{SatW{1'b0}}, sat_quo};
  assign val_ext = {{ValW{1'b0}}, bdly_q[QW-2]};
  assign hue_d   = grey_q[QW-1] ? '0 : hue_ext[HueW-1:0];
  assign sat_d   = grey_q[QW-1] ? '0 : sat_ext[SatW-1:0];
  assign val_d   = val_ext[ValW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q <= hue_d;
    sat_q <= sat_d;
    val_q <= val_d;
  end

  assign done_o       = done_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = val_q;

  // checks
  `RHC_ASSERT(a_never_busy, !busy, "converter raised busy")
  `RHC_ASSERT_IMP(a_hue_range, done_o, longint'(hue_o) < HueLim, "hue out of range")
  `RHC_ASSERT_IMP(a_sat_range, done_o, longint'(saturation_o) <= SatLim,
                  "saturation out of range")
  `RHC_ASSERT_IMP(a_grey_hue, done_o && saturation_o == '0, hue_o == '0,
                  "hue nonzero on a grey sample")

endmodule
